@@ rtl/core/tsc_pkg.sv @@
// package for the tilt sector classifier: field widths, reset values,
// quadrant codes and the entry type carried from the classifier to the counter stage
// no dependencies
package tsc_pkg;

    localparam int TILT_W          = 16;
    localparam int DZ_W            = 15;
    localparam int SECTOR_W        = 5;
    localparam int MCOUNT_W        = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int SECTORS_PER_QUAD = 6;

    localparam logic [DZ_W-1:0] DZ_RESET = 15'd1000;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // one classified sample
    typedef struct packed {
        logic                moved;
        logic [SECTOR_W-1:0] sector;
    } class_t;

endpackage

@@ rtl/core/tsc_classify.sv @@
// front part: dead zone register, credit count and the three-step sector classifier
// depends on tsc_pkg
module tsc_classify
    import tsc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [DZ_W-1:0]          dead_zone,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [TILT_W-1:0] x_tilt,
    input  logic signed [TILT_W-1:0] y_tilt,
    input  logic                     credit_return,
    output logic                     push,
    output class_t                   push_data
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [OCC_W-1:0] OCC_MAX = OCC_W'(QUEUE_DEPTH);

    logic [DZ_W-1:0]  dz_reg;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic             in_accept;

    // step 1 registers
    logic              s1_valid_reg;
    logic              s1_centered_reg;
    logic              s1_zero_reg;
    quad_t             s1_quad_reg;
    logic [TILT_W-1:0] s1_u_reg;
    logic [TILT_W-1:0] s1_v_reg;

    // step 2 registers
    logic                   s2_valid_reg;
    logic                   s2_centered_reg;
    logic                   s2_zero_reg;
    quad_t                  s2_quad_reg;
    logic                   s2_a_nonpos_reg;
    logic                   s2_ge45_reg;
    logic [2*TILT_W-1:0]    s2_uu_reg;
    logic [2*TILT_W-1:0]    s2_vv_reg;
    logic [2*TILT_W:0]      s2_aa_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = (occ_reg == OCC_MAX);
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg <= DZ_RESET;
        end
        else if (cfg_valid)
        begin
            dz_reg <= dead_zone;
        end
    end

    // credits cover both steps and the queue
    always_comb
    begin
        occ_next = occ_reg;
        if (in_accept && !credit_return)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (!in_accept && credit_return)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg      <= occ_next;
            s1_valid_reg <= in_accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // step 1: dead zone test, quadrant and rotation into the first quadrant
    logic signed [TILT_W:0] xs, ys, dzs, ndzs, nx, ny;
    logic                   centered, zero;
    quad_t                  quad;
    logic [TILT_W-1:0]      u, v;

    always_comb
    begin
        xs   = (TILT_W+1)'(x_tilt);
        ys   = (TILT_W+1)'(y_tilt);
        dzs  = signed'({2'b00, dz_reg});
        ndzs = -dzs;
        nx   = -xs;
        ny   = -ys;
        centered = (xs > ndzs) && (xs < dzs) && (ys > ndzs) && (ys < dzs);
        zero     = (xs == '0) && (ys == '0);
        if (xs > 0 && ys >= 0)
        begin
            quad = QUAD_0;
            u    = xs[TILT_W-1:0];
            v    = ys[TILT_W-1:0];
        end
        else if (xs <= 0 && ys > 0)
        begin
            quad = QUAD_1;
            u    = ys[TILT_W-1:0];
            v    = nx[TILT_W-1:0];
        end
        else if (xs < 0 && ys <= 0)
        begin
            quad = QUAD_2;
            u    = nx[TILT_W-1:0];
            v    = ny[TILT_W-1:0];
        end
        else if (xs >= 0 && ys < 0)
        begin
            quad = QUAD_3;
            u    = ny[TILT_W-1:0];
            v    = xs[TILT_W-1:0];
        end
        else
        begin
            quad = QUAD_0;
            u    = '0;
            v    = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_centered_reg <= centered;
            s1_zero_reg     <= zero;
            s1_quad_reg     <= quad;
            s1_u_reg        <= u;
            s1_v_reg        <= v;
        end
    end

    // step 2: squares of u, v and of a = 2u - v
    logic signed [TILT_W+1:0] a1;
    logic [TILT_W:0]          a_abs;
    logic                     a_nonpos;

    always_comb
    begin
        a1       = signed'({1'b0, s1_u_reg, 1'b0}) - signed'({2'b00, s1_v_reg});
        a_nonpos = a1[TILT_W+1] || (a1 == '0);
        a_abs    = a1[TILT_W+1] ? (TILT_W+1)'(0) - a1[TILT_W:0] : a1[TILT_W:0];
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_centered_reg <= s1_centered_reg;
            s2_zero_reg     <= s1_zero_reg;
            s2_quad_reg     <= s1_quad_reg;
            s2_a_nonpos_reg <= a_nonpos;
            s2_ge45_reg     <= (s1_v_reg >= s1_u_reg);
            s2_uu_reg       <= s1_u_reg * s1_u_reg;
            s2_vv_reg       <= s1_v_reg * s1_v_reg;
            s2_aa_reg       <= (2*TILT_W+1)'(a_abs) * (2*TILT_W+1)'(a_abs);
        end
    end

    // step 3: boundary compares with sqrt3 squared away, then the sector number
    logic [2*TILT_W+1:0] uu3, vv3, uu_x, vv_x, aa_x;
    logic                b15, b30, b60, b75;
    logic [2:0]          passed;

    always_comb
    begin
        uu_x = (2*TILT_W+2)'(s2_uu_reg);
        vv_x = (2*TILT_W+2)'(s2_vv_reg);
        aa_x = (2*TILT_W+2)'(s2_aa_reg);
        uu3  = uu_x + {uu_x[2*TILT_W:0], 1'b0};
        vv3  = vv_x + {vv_x[2*TILT_W:0], 1'b0};
        b15  = s2_a_nonpos_reg || (uu3 >= aa_x);
        b30  = (vv3 >= uu_x);
        b60  = (vv_x >= uu3);
        b75  = s2_a_nonpos_reg && (aa_x >= uu3);
        if (s2_zero_reg)
        begin
            passed = '0;
        end
        else
        begin
            passed = 3'(b15) + 3'(b30) + 3'(s2_ge45_reg) + 3'(b60) + 3'(b75);
        end
        push             = s2_valid_reg;
        push_data.moved  = !s2_centered_reg;
        if (s2_centered_reg)
        begin
            push_data.sector = '0;
        end
        else
        begin
            push_data.sector = SECTOR_W'(1) + SECTOR_W'(s2_quad_reg) * SECTOR_W'(SECTORS_PER_QUAD)
                             + SECTOR_W'(passed);
        end
    end

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_MAX)
        else $error("credit count above queue depth");
    a_occ_covers_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == '0 |-> !s1_valid_reg && !s2_valid_reg)
        else $error("sample in flight without a credit");
`endif

endmodule

@@ rtl/core/tsc_queue.sv @@
// short first-in first-out queue of classified samples between front and back
// depends on tsc_pkg
module tsc_queue
    import tsc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  class_t push_data,
    input  logic   pop,
    output logic   empty,
    output class_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    class_t           entries [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign head  = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg != CNT_MAX)
        else $error("write into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("read from empty queue");
`endif

endmodule

@@ rtl/core/tsc_count.sv @@
// back part: saturating moved counter and the output register toward the receiver
// depends on tsc_pkg
module tsc_count
    import tsc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  class_t              q_head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SECTOR_W-1:0] sector,
    output logic [MCOUNT_W-1:0] moved_count
);

    localparam logic [31:0] MC_SAT = 32'((64'd1 << MCOUNT_W) - 64'd1);

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SECTOR_W-1:0]    sector_reg;
    logic [MCOUNT_W-1:0]    moved_count_reg, moved_count_next;
    logic [31:0]            count_wide;

    assign pop = !q_empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        count_next = count_reg;
        if (pop && q_head.moved && (count_reg != '1))
        begin
            count_next = count_reg + 1'b1;
        end
        count_wide = 32'(count_next);
        moved_count_next = (count_wide > MC_SAT) ? MCOUNT_W'(MC_SAT)
                                                 : count_wide[MCOUNT_W-1:0];
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sector_reg      <= q_head.sector;
            moved_count_reg <= moved_count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sector      = sector_reg;
    assign moved_count = moved_count_reg;

`ifndef ASSERT_OFF
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= $past(count_reg))
        else $error("moved counter went down");
`endif

endmodule

@@ rtl/core/tilt_sector_classifier.sv @@
// Tilt sector classifier, top level: classifier front, sample queue, counter back.
// Depends on tsc_pkg, tsc_classify, tsc_queue and tsc_count.
//
// Each sample (x_tilt, y_tilt) transfers when in_valid is high and in_stall low.
// A sample with both parts strictly inside +-dead_zone gives sector 0; any other
// gives sector 1..24 for the fifteen-degree slice of its angle and bumps the
// saturating moved counter; moved_count is the counter value after that sample.
// A result transfers when out_valid is high and out_stall low.
// dead_zone is written over the cfg_valid / cfg_ready channel (ready always high)
// and must only be changed while no sample is in flight.
// A sample passes the step 1 and step 2 registers, the queue and the output
// register before its result reaches the outputs. Throughput: one sample per cycle
// while in_stall is low, set by the one-sample-per-cycle multiply stage and a
// queue of QUEUE_DEPTH entries that covers the two classifier steps.
// While the receiver stalls, results pile up in the queue; in_stall rises once
// QUEUE_DEPTH samples are in flight and falls as results are taken.
// Reset clears the counter, the queue and the pipeline and sets dead_zone to 1000.
module tilt_sector_classifier
    import tsc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [DZ_W-1:0]          dead_zone,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [TILT_W-1:0] x_tilt,
    input  logic signed [TILT_W-1:0] y_tilt,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [SECTOR_W-1:0]      sector,
    output logic [MCOUNT_W-1:0]      moved_count
);

    logic   push, pop, q_empty;
    class_t push_data, q_head;

    tsc_classify #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_classify (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .dead_zone     (dead_zone),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .x_tilt        (x_tilt),
        .y_tilt        (y_tilt),
        .credit_return (pop),
        .push          (push),
        .push_data     (push_data)
    );

    tsc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    tsc_count #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_count (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sector      (sector),
        .moved_count (moved_count)
    );

endmodule

@@ tb/tilt_sector_classifier_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for tilt_sector_classifier: directed and random samples,
// checked against an integer sector predictor; depends on tsc_pkg and the rtl
module tilt_sector_classifier_tb
    import tsc_pkg::*;
();

    localparam int  CYCLE_LIMIT  = 2_000_000;
    localparam int  DRAIN_CYCLES = 8;
    localparam int  PHASE_ITEMS  = 240;
    localparam int  MOVED_MAX    = (1 << COUNT_WIDTH_DEF) - 1;
    localparam int  MOVED_SHOWN  = (1 << MCOUNT_W) - 1;
    localparam real PI           = 3.14159265358979;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [MCOUNT_W-1:0] moved_count;
    } tilt_result_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY
    } rx_mode_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [DZ_W-1:0]          dead_zone;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [TILT_W-1:0] x_tilt;
    logic signed [TILT_W-1:0] y_tilt;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [SECTOR_W-1:0]      sector;
    logic [MCOUNT_W-1:0]      moved_count;

    tilt_result_t    pending_results[$];
    tilt_result_t    oldest_result;
    logic [DZ_W-1:0] zone_model;
    int              moved_model;
    int              err_count = 0;
    int              cycle_count = 0;
    rx_mode_t        rx_mode = RX_FREE;
    int              rx_run;
    int              tx_max_gap;
    int              burst_left;

    tilt_sector_classifier dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .dead_zone  (dead_zone),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .x_tilt     (x_tilt),
        .y_tilt     (y_tilt),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sector     (sector),
        .moved_count(moved_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tilt_sector_classifier test failed");
            $finish;
        end
    end

    // receiver stalls: none in RX_FREE, else alternating open and stalled random runs
    always @(posedge clk)
    begin
        if (rx_mode == RX_FREE)
        begin
            out_stall <= 1'b0;
            rx_run    <= 0;
        end
        else if (rx_run == 0)
        begin
            if (out_stall)
            begin
                out_stall <= 1'b0;
                rx_run    <= (rx_mode == RX_HEAVY) ? $urandom_range(1, 4) : $urandom_range(1, 8);
            end
            else
            begin
                out_stall <= 1'b1;
                rx_run    <= (rx_mode == RX_HEAVY) ? $urandom_range(4, 20) : $urandom_range(1, 3);
            end
        end
        else
        begin
            rx_run <= rx_run - 1;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= 30)
            $display("mismatch: %s got %0d expected %0d (cycle %0d)", what, got, want,
                     cycle_count);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result transfer with nothing pending, sector",
                                int'(sector), 0);
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (sector !== oldest_result.sector)
                    report_mismatch("sector", int'(sector), int'(oldest_result.sector));
                if (moved_count !== oldest_result.moved_count)
                    report_mismatch("moved_count", int'(moved_count),
                                    int'(oldest_result.moved_count));
            end
        end
    end

    // sector from signs, a 90 degree rotation and squared tangent comparisons
    function automatic logic [SECTOR_W-1:0] expected_sector(
        input logic signed [TILT_W-1:0] xs,
        input logic signed [TILT_W-1:0] ys,
        input logic [DZ_W-1:0]          dz
    );
        longint x, y, d, u, v, a;
        quad_t  q;
        int     passed;
        x = xs;
        y = ys;
        d = longint'({1'b0, dz});
        passed = 0;
        if (x > -d && x < d && y > -d && y < d)
            return '0;
        if (x > 0 && y >= 0)
        begin
            q = QUAD_0; u = x; v = y;
        end
        else if (x <= 0 && y > 0)
        begin
            q = QUAD_1; u = y; v = -x;
        end
        else if (x < 0 && y <= 0)
        begin
            q = QUAD_2; u = -x; v = -y;
        end
        else if (x >= 0 && y < 0)
        begin
            q = QUAD_3; u = -y; v = x;
        end
        else
        begin
            q = QUAD_0; u = 0; v = 0;
        end
        if (u != 0 || v != 0)
        begin
            a = 2 * u - v;
            if (a <= 0 || 3 * u * u >= a * a)
                passed++;
            if (3 * v * v >= u * u)
                passed++;
            if (v >= u)
                passed++;
            if (v * v >= 3 * u * u)
                passed++;
            a = v - 2 * u;
            if (a >= 0 && a * a >= 3 * u * u)
                passed++;
        end
        return SECTOR_W'(1 + SECTORS_PER_QUAD * int'(q) + passed);
    endfunction

    function automatic logic signed [TILT_W-1:0] clamp_tilt(input int val);
        if (val > 32767)
            return 16'sh7fff;
        if (val < -32768)
            return 16'sh8000;
        return TILT_W'(val);
    endfunction

    // one sample transfer; the expectation is queued at the accepting edge
    task automatic send_sample(input int xi, input int yi);
        tilt_result_t             res;
        logic signed [TILT_W-1:0] xs, ys;
        xs = TILT_W'(xi);
        ys = TILT_W'(yi);
        in_valid <= 1'b1;
        x_tilt   <= xs;
        y_tilt   <= ys;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res.sector = expected_sector(xs, ys, zone_model);
        if (res.sector != 0 && moved_model < MOVED_MAX)
            moved_model++;
        res.moved_count = (moved_model > MOVED_SHOWN) ? MOVED_SHOWN : moved_model;
        pending_results.push_back(res);
    endtask

    // bursts of random length separated by random gaps
    task automatic pace_sender();
        int gap;
        if (tx_max_gap == 0)
            return;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_dead_zone(input logic [DZ_W-1:0] val);
        wait_for_drain();
        cfg_valid <= 1'b1;
        dead_zone <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        zone_model = val;
    endtask

    task automatic pick_sample(output logic signed [TILT_W-1:0] xs,
                               output logic signed [TILT_W-1:0] ys);
        int  kind, k, c, other, dz;
        real th, r;
        kind = $urandom_range(0, 99);
        dz   = int'({1'b0, zone_model});
        if (kind < 30)
        begin
            xs = TILT_W'($urandom);
            ys = TILT_W'($urandom);
        end
        else if (kind < 55)
        begin
            // near a fifteen-degree boundary
            th = $urandom_range(0, 23) * 15.0 * PI / 180.0;
            r  = $urandom_range(1, 32767);
            xs = clamp_tilt($rtoi(r * $cos(th)) + int'($urandom_range(0, 4)) - 2);
            ys = clamp_tilt($rtoi(r * $sin(th)) + int'($urandom_range(0, 4)) - 2);
        end
        else if (kind < 75)
        begin
            // one component at the edge of the dead zone
            c = dz + int'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 1))
                c = -c;
            other = int'($urandom_range(0, 2 * dz)) - dz;
            if ($urandom_range(0, 1))
            begin
                xs = clamp_tilt(c); ys = clamp_tilt(other);
            end
            else
            begin
                xs = clamp_tilt(other); ys = clamp_tilt(c);
            end
        end
        else if (kind < 87)
        begin
            // exactly on an axis or a diagonal
            k = (kind == 86) ? 32768 : int'($urandom_range(1, 32767));
            case ($urandom_range(0, 7))
                0: begin xs = clamp_tilt(k);  ys = '0;             end
                1: begin xs = clamp_tilt(k);  ys = clamp_tilt(k);  end
                2: begin xs = '0;             ys = clamp_tilt(k);  end
                3: begin xs = clamp_tilt(-k); ys = clamp_tilt(k);  end
                4: begin xs = clamp_tilt(-k); ys = '0;             end
                5: begin xs = clamp_tilt(-k); ys = clamp_tilt(-k); end
                6: begin xs = '0;             ys = clamp_tilt(-k); end
                default: begin xs = clamp_tilt(k); ys = clamp_tilt(-k); end
            endcase
        end
        else
        begin
            xs = clamp_tilt(int'($urandom_range(0, 4)) - 2);
            ys = clamp_tilt(int'($urandom_range(0, 4)) - 2);
        end
    endtask

    task automatic test_reset_dead_zone();
        send_sample(0, 0);
        send_sample(999, -999);
        send_sample(-999, 999);
        send_sample(999, -1000);
        send_sample(1000, 0);
        send_sample(0, 1000);
        send_sample(-1000, 0);
        send_sample(0, -1000);
        send_sample(1000, 1000);
        send_sample(-1000, -1000);
        send_sample(32767, -32768);
        send_sample(-32768, 32767);
        send_sample(-32768, -32768);
        send_sample(32767, 32767);
    endtask

    task automatic test_dead_zone_extremes();
        // zero vector is not centered when the zone is zero
        write_dead_zone('0);
        send_sample(0, 0);
        send_sample(1, 0);
        send_sample(0, -1);
        send_sample(-1, -1);
        write_dead_zone({DZ_W{1'b1}});
        send_sample(32767, -32767);
        send_sample(-32768, 0);
        send_sample(0, -32768);
        send_sample(-32768, -32768);
    endtask

    task automatic test_random_samples();
        logic signed [TILT_W-1:0] xs, ys;
        logic [DZ_W-1:0]          zone;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: zone = DZ_RESET;
                1: zone = '0;
                2: zone = {DZ_W{1'b1}};
                3: zone = DZ_W'(1);
                4: zone = DZ_W'(16384);
                default: zone = DZ_W'($urandom);
            endcase
            write_dead_zone(zone);
            rx_mode    <= rx_mode_t'(phase % 3);
            tx_max_gap = (phase % 4 == 0) ? 0 : int'($urandom_range(1, 6));
            burst_left = 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // the sender holds off once until the block has emptied
                if (phase == 5 && i == PHASE_ITEMS / 2)
                    wait_for_drain();
                pick_sample(xs, ys);
                send_sample(int'(xs), int'(ys));
                pace_sender();
            end
        end
    endtask

    task automatic test_counter_running();
        logic signed [TILT_W-1:0] xs, ys;
        write_dead_zone('0);
        rx_mode    <= RX_LIGHT;
        tx_max_gap = 0;
        for (int i = 0; i < 10; i++)
            send_sample(int'($urandom_range(0, 65535)) - 32768,
                        int'($urandom_range(0, 65535)) - 32768);
        write_dead_zone(DZ_RESET);
        for (int i = 0; i < 20; i++)
        begin
            pick_sample(xs, ys);
            send_sample(int'(xs), int'(ys));
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        dead_zone   <= DZ_RESET;
        in_valid    <= 1'b0;
        x_tilt      <= '0;
        y_tilt      <= '0;
        zone_model  = DZ_RESET;
        moved_model = 0;
        tx_max_gap  = 0;
        burst_left  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_dead_zone();
        test_dead_zone_extremes();
        test_random_samples();
        test_counter_running();
        wait_for_drain();

        if (err_count == 0)
            $display("tilt_sector_classifier test passed");
        else
            $display("tilt_sector_classifier test failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/tsc_pkg.sv
rtl/core/tsc_classify.sv
rtl/core/tsc_queue.sv
rtl/core/tsc_count.sv
rtl/core/tilt_sector_classifier.sv
tb/tilt_sector_classifier_tb.sv
